// File: design/sha1h_pkg.sv
// sha1h_pkg: shared types, constants and the control program of the sha-1 byte stream hasher
// no dependencies; imported by the sequencer, the datapath and the top level
`default_nettype none
package sha1h_pkg;

   localparam int WORD_W = 32;
   localparam int FILL_W = 6;
   localparam int ROUND_W = 7;
   localparam int IDX_W = 3;
   localparam int NUM_CHAIN = 5;
   localparam int NUM_SCHED = 16;

   localparam logic [WORD_W-1:0] IV0 = 32'h67452301;
   localparam logic [WORD_W-1:0] IV1 = 32'hefcdab89;
   localparam logic [WORD_W-1:0] IV2 = 32'h98badcfe;
   localparam logic [WORD_W-1:0] IV3 = 32'h10325476;
   localparam logic [WORD_W-1:0] IV4 = 32'hc3d2e1f0;
   localparam logic [WORD_W-1:0] K0 = 32'h5a827999;
   localparam logic [WORD_W-1:0] K1 = 32'h6ed9eba1;
   localparam logic [WORD_W-1:0] K2 = 32'h8f1bbcdc;
   localparam logic [WORD_W-1:0] K3 = 32'hca62c1d6;
   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [FILL_W-1:0] FILL_FULL = 6'd63;
   localparam logic [FILL_W-1:0] FILL_LEN = 6'd56;
   localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;
   localparam logic [ROUND_W-1:0] ROUND_20 = 7'd20;
   localparam logic [ROUND_W-1:0] ROUND_40 = 7'd40;
   localparam logic [ROUND_W-1:0] ROUND_60 = 7'd60;
   localparam logic [IDX_W-1:0] IDX_LAST = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PAD80,
      ST_PADZ,
      ST_LENHI,
      ST_LENLO,
      ST_CINIT,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } step_type;

   typedef enum logic [3:0] {
      OP_BYTE,
      OP_MARK,
      OP_ZERO,
      OP_LENHI,
      OP_LENLO,
      OP_LOAD,
      OP_ROUND,
      OP_ADD,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      J_IDLE,
      J_PAD80,
      J_PADZ,
      J_NEXT,
      J_ROUND,
      J_ADD,
      J_EMIT
   } jump_type;

   typedef struct packed {
      logic     in_ready;
      logic     out_valid;
      op_type   op;
      jump_type jump;
      step_type target;
   } ctrl_type;

   typedef struct packed {
      logic fill_full;
      logic fill_len;
      logic round_last;
      logic emit_last;
      logic last_pend;
      logic mark_done;
      logic final_blk;
   } status_type;

   // control store: one word per step
   function automatic ctrl_type microcode(input step_type step);
      ctrl_type w;
      w = '{in_ready: 1'b0, out_valid: 1'b0, op: OP_BYTE, jump: J_IDLE, target: ST_IDLE};
      unique case (step)
         ST_IDLE: begin
            w.in_ready = 1'b1;
            w.op = OP_BYTE;
            w.jump = J_IDLE;
         end
         ST_PAD80: begin
            w.op = OP_MARK;
            w.jump = J_PAD80;
         end
         ST_PADZ: begin
            w.op = OP_ZERO;
            w.jump = J_PADZ;
         end
         ST_LENHI: begin
            w.op = OP_LENHI;
            w.jump = J_NEXT;
            w.target = ST_LENLO;
         end
         ST_LENLO: begin
            w.op = OP_LENLO;
            w.jump = J_NEXT;
            w.target = ST_CINIT;
         end
         ST_CINIT: begin
            w.op = OP_LOAD;
            w.jump = J_NEXT;
            w.target = ST_ROUND;
         end
         ST_ROUND: begin
            w.op = OP_ROUND;
            w.jump = J_ROUND;
         end
         ST_ADD: begin
            w.op = OP_ADD;
            w.jump = J_ADD;
         end
         ST_EMIT: begin
            w.out_valid = 1'b1;
            w.op = OP_EMIT;
            w.jump = J_EMIT;
         end
         default: begin
            w.jump = J_NEXT;
            w.target = ST_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// File: design/sha1_byte_stream_hasher.sv
// sha1_byte_stream_hasher: top level, sequencer plus datapath
// depends on sha1h_pkg, sha1h_sequencer and sha1h_datapath
//
// channel  direction  tdata             tuser        tlast
// req_     in         data_byte [7:0]   has_byte     is_last
// rsp_     out        digest_word[31:0] word_index   last_word
//
// one byte is taken per cycle while the input is ready; every 64th byte stops input
// while its block is compressed (load, the rounds of the shared round unit, chaining add)
// the end of a message adds the padding bytes (1 to 64), the two length words and one or
// two compressions, then five digest transactions
// reset is synchronous and loads the initial vector; no clearing pass
// a stalled digest transaction holds its data; no input is taken until all five are taken
`default_nettype none
module sha1_byte_stream_hasher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte [7:0]
   input  wire logic [0:0]  req_tuser,   // has_byte [0]
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // digest_word [31:0]
   output logic [2:0]       rsp_tuser,   // word_index [2:0]
   output logic             rsp_tlast
);
   import sha1h_pkg::*;

   ctrl_type   ctrl;
   status_type status;
   logic       req_fire;
   logic       rsp_fire;

   assign req_tready = ctrl.in_ready;
   assign rsp_tvalid = ctrl.out_valid;
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   sha1h_sequencer u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_fire     (req_fire),
      .req_has_byte (req_tuser[0]),
      .req_last     (req_tlast),
      .rsp_fire     (rsp_fire),
      .status       (status),
      .ctrl         (ctrl)
   );

   sha1h_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .req_fire     (req_fire),
      .req_data     (req_tdata),
      .req_has_byte (req_tuser[0]),
      .req_last     (req_tlast),
      .rsp_fire     (rsp_fire),
      .status       (status),
      .digest_word  (rsp_tdata),
      .word_index   (rsp_tuser),
      .last_word    (rsp_tlast)
   );

endmodule
`default_nettype wire

// File: design/sha1h_sequencer.sv
// sha1h_sequencer: step counter over the control store with conditional jumps
// depends on sha1h_pkg
`default_nettype none
module sha1h_sequencer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_fire,
   input  wire logic                  req_has_byte,
   input  wire logic                  req_last,
   input  wire logic                  rsp_fire,
   input  wire sha1h_pkg::status_type status,
   output sha1h_pkg::ctrl_type        ctrl
);
   import sha1h_pkg::*;

   step_type pc_ff;
   step_type pc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   always_comb begin
      ctrl = microcode(pc_ff);
   end

   always_comb begin
      ctrl_type w;
      w = microcode(pc_ff);
      pc_in = pc_ff;
      unique case (w.jump)
         J_IDLE: begin
            priority if (!req_fire) begin
               pc_in = ST_IDLE;
            end else if (req_has_byte && status.fill_full) begin
               pc_in = ST_CINIT;
            end else if (req_last) begin
               pc_in = ST_PAD80;
            end else begin
               pc_in = ST_IDLE;
            end
         end
         J_PAD80: begin
            pc_in = status.fill_full ? ST_CINIT : ST_PADZ;
         end
         J_PADZ: begin
            priority if (status.fill_len) begin
               pc_in = ST_LENHI;
            end else if (status.fill_full) begin
               pc_in = ST_CINIT;
            end else begin
               pc_in = ST_PADZ;
            end
         end
         J_NEXT: begin
            pc_in = w.target;
         end
         J_ROUND: begin
            pc_in = status.round_last ? ST_ADD : ST_ROUND;
         end
         J_ADD: begin
            priority if (status.final_blk) begin
               pc_in = ST_EMIT;
            end else if (status.last_pend && status.mark_done) begin
               pc_in = ST_PADZ;
            end else if (status.last_pend) begin
               pc_in = ST_PAD80;
            end else begin
               pc_in = ST_IDLE;
            end
         end
         J_EMIT: begin
            pc_in = (rsp_fire && status.emit_last) ? ST_IDLE : ST_EMIT;
         end
         default: begin
            pc_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: design/sha1h_datapath.sv
// sha1h_datapath: byte packing, schedule shift line, round logic, chaining words and length
// depends on sha1h_pkg; driven by the control word from sha1h_sequencer
`default_nettype none
module sha1h_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sha1h_pkg::ctrl_type   ctrl,
   input  wire logic                  req_fire,
   input  wire logic [7:0]            req_data,
   input  wire logic                  req_has_byte,
   input  wire logic                  req_last,
   input  wire logic                  rsp_fire,
   output sha1h_pkg::status_type      status,
   output logic [31:0]                digest_word,
   output logic [2:0]                 word_index,
   output logic                       last_word
);
   import sha1h_pkg::*;

   logic [WORD_W-1:0] chain_ff [NUM_CHAIN];
   logic [WORD_W-1:0] chain_in [NUM_CHAIN];
   logic [WORD_W-1:0] work_ff  [NUM_CHAIN];
   logic [WORD_W-1:0] work_in  [NUM_CHAIN];
   logic [WORD_W-1:0] sched_ff [NUM_SCHED];
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [63:0]       bitlen_ff, bitlen_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic [IDX_W-1:0]  emit_ff, emit_in;
   logic              last_ff, last_in;
   logic              mark_ff, mark_in;
   logic              final_ff, final_in;

   logic              shift_en;
   logic [WORD_W-1:0] shift_word;
   logic              byte_en;
   logic [7:0]        byte_val;
   logic [WORD_W-1:0] f_val, k_val, t_val, sched_new;

   // round function and schedule expansion
   always_comb begin
      logic [WORD_W-1:0] b, c, d, x;
      b = work_ff[1];
      c = work_ff[2];
      d = work_ff[3];
      priority if (round_ff < ROUND_20) begin
         f_val = (b & c) | (~b & d);
         k_val = K0;
      end else if (round_ff < ROUND_40) begin
         f_val = b ^ c ^ d;
         k_val = K1;
      end else if (round_ff < ROUND_60) begin
         f_val = (b & c) | (b & d) | (c & d);
         k_val = K2;
      end else begin
         f_val = b ^ c ^ d;
         k_val = K3;
      end
      t_val = {work_ff[0][26:0], work_ff[0][31:27]} + f_val + work_ff[4] + k_val + sched_ff[0];
      x = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];
      sched_new = {x[30:0], x[31]};
   end

   always_comb begin
      acc_in = acc_ff;
      fill_in = fill_ff;
      bitlen_in = bitlen_ff;
      round_in = round_ff;
      emit_in = emit_ff;
      last_in = last_ff;
      mark_in = mark_ff;
      final_in = final_ff;
      shift_en = 1'b0;
      shift_word = '0;
      byte_en = 1'b0;
      byte_val = '0;
      for (int i = 0; i < NUM_CHAIN; i++) begin
         chain_in[i] = chain_ff[i];
         work_in[i] = work_ff[i];
      end
      unique case (ctrl.op)
         OP_BYTE: begin
            if (req_fire) begin
               last_in = req_last;
               if (req_has_byte) begin
                  byte_en = 1'b1;
                  byte_val = req_data;
                  bitlen_in = bitlen_ff + 64'd8;
               end
            end
         end
         OP_MARK: begin
            byte_en = 1'b1;
            byte_val = PAD_MARK;
            mark_in = 1'b1;
         end
         OP_ZERO: begin
            byte_en = (fill_ff != FILL_LEN);
         end
         OP_LENHI: begin
            shift_en = 1'b1;
            shift_word = bitlen_ff[63:32];
            fill_in = fill_ff + 6'd4;
         end
         OP_LENLO: begin
            shift_en = 1'b1;
            shift_word = bitlen_ff[31:0];
            fill_in = fill_ff + 6'd4;
            final_in = 1'b1;
         end
         OP_LOAD: begin
            for (int i = 0; i < NUM_CHAIN; i++) begin
               work_in[i] = chain_ff[i];
            end
            round_in = '0;
         end
         OP_ROUND: begin
            work_in[4] = work_ff[3];
            work_in[3] = work_ff[2];
            work_in[2] = {work_ff[1][1:0], work_ff[1][31:2]};
            work_in[1] = work_ff[0];
            work_in[0] = t_val;
            shift_en = 1'b1;
            shift_word = sched_new;
            round_in = round_ff + 7'd1;
         end
         OP_ADD: begin
            for (int i = 0; i < NUM_CHAIN; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
         end
         OP_EMIT: begin
            if (rsp_fire) begin
               if (emit_ff == IDX_LAST) begin
                  chain_in[0] = IV0;
                  chain_in[1] = IV1;
                  chain_in[2] = IV2;
                  chain_in[3] = IV3;
                  chain_in[4] = IV4;
                  bitlen_in = '0;
                  fill_in = '0;
                  emit_in = '0;
                  last_in = 1'b0;
                  mark_in = 1'b0;
                  final_in = 1'b0;
               end else begin
                  emit_in = emit_ff + 3'd1;
               end
            end
         end
         default: begin
         end
      endcase
      // big-endian byte packing, a full word drops into the schedule line
      if (byte_en) begin
         acc_in = {acc_ff[23:0], byte_val};
         fill_in = fill_ff + 6'd1;
         if (fill_ff[1:0] == 2'b11) begin
            shift_en = 1'b1;
            shift_word = acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff[0] <= IV0;
         chain_ff[1] <= IV1;
         chain_ff[2] <= IV2;
         chain_ff[3] <= IV3;
         chain_ff[4] <= IV4;
         bitlen_ff <= '0;
         fill_ff <= '0;
         round_ff <= '0;
         emit_ff <= '0;
         last_ff <= 1'b0;
         mark_ff <= 1'b0;
         final_ff <= 1'b0;
      end else begin
         for (int i = 0; i < NUM_CHAIN; i++) begin
            chain_ff[i] <= chain_in[i];
         end
         bitlen_ff <= bitlen_in;
         fill_ff <= fill_in;
         round_ff <= round_in;
         emit_ff <= emit_in;
         last_ff <= last_in;
         mark_ff <= mark_in;
         final_ff <= final_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      for (int i = 0; i < NUM_CHAIN; i++) begin
         work_ff[i] <= work_in[i];
      end
      if (shift_en) begin
         for (int i = 0; i < NUM_SCHED - 1; i++) begin
            sched_ff[i] <= sched_ff[i+1];
         end
         sched_ff[NUM_SCHED-1] <= shift_word;
      end
   end

   always_comb begin
      status.fill_full = (fill_ff == FILL_FULL);
      status.fill_len = (fill_ff == FILL_LEN);
      status.round_last = (round_ff == ROUND_LAST);
      status.emit_last = (emit_ff == IDX_LAST);
      status.last_pend = last_ff;
      status.mark_done = mark_ff;
      status.final_blk = final_ff;
   end

   always_comb begin
      unique case (emit_ff)
         3'd0: digest_word = chain_ff[0];
         3'd1: digest_word = chain_ff[1];
         3'd2: digest_word = chain_ff[2];
         3'd3: digest_word = chain_ff[3];
         default: digest_word = chain_ff[4];
      endcase
      word_index = emit_ff;
      last_word = (emit_ff == IDX_LAST);
   end

endmodule
`default_nettype wire

// File: design/sha1h_checker.sv
// sha1h_checker: port-level checks of the hasher's digest transactions and input readiness
// bound to sha1_byte_stream_hasher; no other dependencies
`default_nettype none
module sha1h_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // stalled digest word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("digest transaction changed while stalled");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == 3'd4)))
      else $error("tlast not on word four");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while digest pending");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tuser == $past(rsp_tuser) + 3'd1))
      else $error("digest words out of order");

   a_back_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && !rsp_tvalid)
      else $error("not ready for next message after digest");

endmodule

bind sha1_byte_stream_hasher sha1h_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
